/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define PBROT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define PBROT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/pbrot_pkg.sv */
// ----------------------------------------------------------------------------
// pbrot_pkg
// Shared types, codes and helpers of the packed bitmap 90-degree rotator.
// ----------------------------------------------------------------------------
package pbrot_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    // pixel format codes
    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_2BPP  = 3'd1;
    localparam logic [2:0] FMT_4BPP  = 3'd2;
    localparam logic [2:0] FMT_8BPP  = 3'd3;
    localparam logic [2:0] FMT_16BPP = 3'd4;
    localparam logic [2:0] FMT_24BPP = 3'd5;
    localparam logic [2:0] FMT_32BPP = 3'd6;

    // register reset values
    localparam logic [2:0] RST_PIXEL_FORMAT = FMT_8BPP;
    localparam logic [7:0] RST_SRC_WIDTH    = 8'd128;
    localparam logic [7:0] RST_SRC_HEIGHT   = 8'd128;

    // request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // 24 bpp column split: n/3 == (n * DIV3_MUL) >> DIV3_SHIFT for n < 8190
    localparam logic [23:0] DIV3_MUL   = 24'd2731;
    localparam int          DIV3_SHIFT = 13;

    typedef enum logic [1:0] {
        REG_PIXEL_FORMAT = 2'd0,
        REG_SRC_WIDTH    = 2'd1,
        REG_SRC_HEIGHT   = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_RDATA
    } t_state;

    // configuration as seen by the datapath, dimensions already clamped
    typedef struct packed {
        logic [2:0] code;
        logic [7:0] w;
        logic [7:0] h;
    } t_cfg;

    function automatic logic [5:0] bpp_of(input logic [2:0] code);
        logic [5:0] bpp;
        case (code)
            FMT_1BPP:  bpp = 6'd1;
            FMT_2BPP:  bpp = 6'd2;
            FMT_4BPP:  bpp = 6'd4;
            FMT_8BPP:  bpp = 6'd8;
            FMT_16BPP: bpp = 6'd16;
            FMT_24BPP: bpp = 6'd24;
            default:   bpp = 6'd32;
        endcase
        return bpp;
    endfunction

endpackage

/* rtl/packed_bitmap_rotate_90_core.sv */
// ----------------------------------------------------------------------------
// packed_bitmap_rotate_90_core
// Rotates a packed-pixel bitmap 90 degrees anticlockwise through a byte store.
// ----------------------------------------------------------------------------
// Usage:
//   Set pixel_format, src_width and src_height over APB (0x0, 0x4, 0x8) while
//   idle. Input beats (valid/stall) either write one source byte
//   (req_type 0) or read one destination byte (req_type 1). Writes give no
//   result; each read gives one result beat with read_data and bad_address.
//   Read the destination only after the whole source has been written.
// Sequence:
//   A source write passes PREP, which decodes the beat, then SCAN, which does
//   one store read-modify-write per cycle for each pixel the byte holds that
//   lies inside the width (8, 4, 2 at 1, 2, 4 bpp; one byte move at 8 bpp and
//   up), and ends with a SCAN step that retires the last write-back.
//   A destination read passes PREP, which reads the store, and RDATA, which
//   loads the output register when it is free, taking the next beat alongside.
//   These steps follow from the store's registered read.
// Reset: control and output valid clear at once; the store content is
//   undefined until written, and the registers return to 8 bpp, 128 x 128.
// A stalled result holds in the output register; the block keeps its input
//   stall high while a finished read cannot be handed over.
// ----------------------------------------------------------------------------
module packed_bitmap_rotate_90_core
    import pbrot_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [6:0]  i_src_row,
    input  logic [8:0]  i_src_byte,
    input  logic [7:0]  i_src_data,
    input  logic [6:0]  i_dst_row,
    input  logic [8:0]  i_dst_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_bad_address
);

    localparam int RW = $clog2(MAX_WIDTH);
    localparam int BW = $clog2(4 * MAX_HEIGHT);
    localparam int AW = RW + BW;

    t_cfg          cfg;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    pbrot_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pbrot_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RW         (RW),
        .BW         (BW),
        .AW         (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_src_row     (i_src_row),
        .i_src_byte    (i_src_byte),
        .i_src_data    (i_src_data),
        .i_dst_row     (i_dst_row),
        .i_dst_byte    (i_dst_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_data   (o_read_data),
        .o_bad_address (o_bad_address),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata)
    );

    pbrot_store #(
        .AW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata)
    );

endmodule

/* rtl/pbrot_store.sv */
// ----------------------------------------------------------------------------
// pbrot_store
// Rotated bitmap store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pbrot_store #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata
);

    localparam int DEPTH = 2 ** AW;

    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pbrot_cfg.sv */
// ----------------------------------------------------------------------------
// pbrot_cfg
// APB register file: pixel format and source dimensions, clamped for use.
// ----------------------------------------------------------------------------
module pbrot_cfg
    import pbrot_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [2:0] r_fmt;
    logic [7:0] r_w;
    logic [7:0] r_h;
    logic       wr_en;
    t_reg_idx   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= RST_PIXEL_FORMAT;
            r_w   <= RST_SRC_WIDTH;
            r_h   <= RST_SRC_HEIGHT;
        end else if (wr_en) begin
            unique case (idx)
                REG_PIXEL_FORMAT: r_fmt <= pwdata[2:0];
                REG_SRC_WIDTH:    r_w   <= pwdata[7:0];
                REG_SRC_HEIGHT:   r_h   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PIXEL_FORMAT: prdata = {29'd0, r_fmt};
            REG_SRC_WIDTH:    prdata = {24'd0, r_w};
            REG_SRC_HEIGHT:   prdata = {24'd0, r_h};
            default:          prdata = 32'd0;
        endcase
    end

    // zero acts as one, oversize saturates to the store's limit
    always_comb begin
        o_cfg.code = r_fmt;
        if (r_w == 8'd0) begin
            o_cfg.w = 8'd1;
        end else if (16'(r_w) > 16'(MAX_WIDTH)) begin
            o_cfg.w = 8'(MAX_WIDTH);
        end else begin
            o_cfg.w = r_w;
        end
        if (r_h == 8'd0) begin
            o_cfg.h = 8'd1;
        end else if (16'(r_h) > 16'(MAX_HEIGHT)) begin
            o_cfg.h = 8'(MAX_HEIGHT);
        end else begin
            o_cfg.h = r_h;
        end
    end

endmodule

/* rtl/pbrot_ctrl.sv */
// ----------------------------------------------------------------------------
// pbrot_ctrl
// Request sequencer: decodes a beat, scatters pixels into the store by
// read-modify-write, and serves destination reads through an output register.
// ----------------------------------------------------------------------------
module pbrot_ctrl
    import pbrot_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int RW         = $clog2(MAX_WIDTH),
    parameter int BW         = $clog2(4 * MAX_HEIGHT),
    parameter int AW         = RW + BW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_req_type,
    input  logic [6:0]    i_src_row,
    input  logic [8:0]    i_src_byte,
    input  logic [7:0]    i_src_data,
    input  logic [6:0]    i_dst_row,
    input  logic [8:0]    i_dst_byte,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_read_data,
    output logic          o_bad_address,
    output logic          o_mem_re,
    output logic [AW-1:0] o_mem_raddr,
    input  logic [7:0]    i_mem_rdata,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output logic [7:0]    o_mem_wdata
);

    t_state r_state, n_state;

    // accepted beat
    logic          r_req, n_req;
    logic [6:0]    r_y, n_y;
    logic [8:0]    r_sbyte, n_sbyte;
    logic [7:0]    r_dat, n_dat;
    logic [6:0]    r_drow, n_drow;
    logic [8:0]    r_dbyte, n_dbyte;

    // decoded write job
    logic [8:0]    r_x, n_x;
    logic [3:0]    r_k, n_k;
    logic [3:0]    r_npix, n_npix;
    logic [BW-1:0] r_col, n_col;
    logic [7:0]    r_mask, n_mask;
    logic [7:0]    r_pm, n_pm;
    logic [2:0]    r_sh, n_sh;
    logic          r_full, n_full;

    // pending write-back of the read issued last cycle
    logic          r_pend, n_pend;
    logic [AW-1:0] r_paddr, n_paddr;
    logic [7:0]    r_pbits, n_pbits;

    // destination read
    logic          r_bad, n_bad;
    logic [7:0]    r_rmask, n_rmask;

    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_data, n_out_data;
    logic          r_out_bad, n_out_bad;

    // decode terms
    logic [5:0]  bpp;
    logic [1:0]  lg;
    logic [3:0]  ppb;
    logic        sub;
    logic [15:0] w16, h16, y16, sb16, dr16, db16;
    logic [15:0] src_pitch, dst_pitch, ybyte;
    logic [23:0] prod3;
    logic [15:0] x_full, j16, xbase;
    logic [2:0]  ymod_inv;
    logic [7:0]  pm;
    logic        wr_ok;
    logic        rd_bad;
    logic [15:0] rbase, rrem;
    logic [3:0]  nvalid;
    logic [15:0] row16;
    logic [AW-1:0] scan_addr;
    logic [7:0]  pix;
    logic        issue;
    logic        load;
    logic        accept;

    assign bpp  = bpp_of(i_cfg.code);
    assign lg   = i_cfg.code[1:0];
    assign ppb  = 4'd8 >> lg;
    assign sub  = (i_cfg.code < FMT_8BPP);
    assign w16  = 16'(i_cfg.w);
    assign h16  = 16'(i_cfg.h);
    assign y16  = 16'(r_y);
    assign sb16 = 16'(r_sbyte);
    assign dr16 = 16'(r_drow);
    assign db16 = 16'(r_dbyte);

    assign src_pitch = (w16 * 16'(bpp) + 16'd7) >> 3;
    assign dst_pitch = (h16 * 16'(bpp) + 16'd7) >> 3;
    assign ybyte     = (y16 * 16'(bpp)) >> 3;
    assign wr_ok     = (y16 < h16) && (sb16 < src_pitch);

    // whole-byte formats: pixel column and byte within the pixel
    assign prod3 = 24'(r_sbyte) * DIV3_MUL;
    always_comb begin
        case (i_cfg.code)
            FMT_8BPP: begin
                x_full = sb16;
                j16    = 16'd0;
            end
            FMT_16BPP: begin
                x_full = sb16 >> 1;
                j16    = {15'd0, r_sbyte[0]};
            end
            FMT_24BPP: begin
                x_full = 16'(prod3 >> DIV3_SHIFT);
                j16    = sb16 - (x_full << 1) - x_full;
            end
            default: begin
                x_full = sb16 >> 2;
                j16    = {14'd0, r_sbyte[1:0]};
            end
        endcase
    end

    // packed formats: first pixel column and bit position in the dest byte
    assign xbase    = sb16 << (2'd3 - lg);
    assign ymod_inv = ~r_y[2:0] & 3'(ppb - 4'd1);
    assign pm       = 8'((16'd1 << bpp) - 16'd1);

    // read side: keep only pixels that fall inside the rotated width
    assign rd_bad = (dr16 >= w16) || (db16 >= dst_pitch);
    assign rbase  = db16 << (2'd3 - lg);
    assign rrem   = h16 - rbase;
    assign nvalid = (rrem >= 16'(ppb)) ? ppb : rrem[3:0];

    // scan step
    assign issue     = (r_k < r_npix) && (16'(r_x) < w16);
    assign row16     = w16 - 16'd1 - 16'(r_x);
    assign scan_addr = {row16[RW-1:0], r_col};
    assign pix       = r_full ? r_dat : ((r_dat >> (4'd8 - 4'(bpp))) & r_pm);

    assign load = !r_out_valid || !i_out_stall;

    // the last scan cycle only retires the final write-back, so a new beat
    // taken there cannot read an entry before that write lands
    always_comb begin
        unique case (r_state)
            ST_IDLE:  accept = 1'b1;
            ST_SCAN:  accept = !issue;
            ST_RDATA: accept = load;
            default:  accept = 1'b0;
        endcase
    end
    assign o_in_stall = !accept;

    assign o_mem_we    = r_pend;
    assign o_mem_waddr = r_paddr;
    assign o_mem_wdata = (i_mem_rdata & ~r_mask) | r_pbits;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_y         = r_y;
        n_sbyte     = r_sbyte;
        n_dat       = r_dat;
        n_drow      = r_drow;
        n_dbyte     = r_dbyte;
        n_x         = r_x;
        n_k         = r_k;
        n_npix      = r_npix;
        n_col       = r_col;
        n_mask      = r_mask;
        n_pm        = r_pm;
        n_sh        = r_sh;
        n_full      = r_full;
        n_pend      = 1'b0;
        n_paddr     = r_paddr;
        n_pbits     = r_pbits;
        n_bad       = r_bad;
        n_rmask     = r_rmask;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        n_out_bad   = r_out_bad;
        o_mem_re    = 1'b0;
        o_mem_raddr = scan_addr;

        unique case (r_state)
            ST_IDLE: ;
            ST_PREP: begin
                if (r_req == REQ_WRITE) begin
                    n_k    = 4'd0;
                    n_full = !sub;
                    n_pm   = pm;
                    if (sub) begin
                        n_x    = 9'(xbase);
                        n_col  = BW'(ybyte);
                        n_npix = wr_ok ? ppb : 4'd0;
                        n_sh   = ymod_inv << lg;
                        n_mask = pm << (ymod_inv << lg);
                    end else begin
                        n_x    = 9'(x_full);
                        n_col  = BW'(ybyte + j16);
                        n_npix = wr_ok ? 4'd1 : 4'd0;
                        n_sh   = 3'd0;
                        n_mask = 8'hFF;
                    end
                    n_state = ST_SCAN;
                end else begin
                    n_bad       = rd_bad;
                    n_rmask     = sub ? 8'(16'h00FF << ((ppb - nvalid) << lg)) : 8'hFF;
                    o_mem_re    = !rd_bad;
                    o_mem_raddr = {dr16[RW-1:0], db16[BW-1:0]};
                    n_state     = ST_RDATA;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    o_mem_re = 1'b1;
                    n_pend   = 1'b1;
                    n_paddr  = scan_addr;
                    n_pbits  = pix << r_sh;
                    n_x      = r_x + 9'd1;
                    n_k      = r_k + 4'd1;
                    n_dat    = r_dat << bpp;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RDATA: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_bad ? 8'd0 : (i_mem_rdata & r_rmask);
                    n_out_bad   = r_bad;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (accept && i_in_valid) begin
            n_req   = i_req_type;
            n_y     = i_src_row;
            n_sbyte = i_src_byte;
            n_dat   = i_src_data;
            n_drow  = i_dst_row;
            n_dbyte = i_dst_byte;
            n_state = ST_PREP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_y        <= n_y;
        r_sbyte    <= n_sbyte;
        r_dat      <= n_dat;
        r_drow     <= n_drow;
        r_dbyte    <= n_dbyte;
        r_x        <= n_x;
        r_k        <= n_k;
        r_npix     <= n_npix;
        r_col      <= n_col;
        r_mask     <= n_mask;
        r_pm       <= n_pm;
        r_sh       <= n_sh;
        r_full     <= n_full;
        r_paddr    <= n_paddr;
        r_pbits    <= n_pbits;
        r_bad      <= n_bad;
        r_rmask    <= n_rmask;
        r_out_data <= n_out_data;
        r_out_bad  <= n_out_bad;
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_out_data;
    assign o_bad_address = r_out_bad;

endmodule

/* rtl/pbrot_chk.sv */
// ----------------------------------------------------------------------------
// pbrot_chk
// Port-level checks of the rotator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbrot_chk
    import pbrot_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_req_type,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_read_data,
    input logic       o_bad_address
);

    // out-of-range reads come back as zero
    `PBROT_ASSERT_NOW(a_bad_reads_zero, i_clk, i_rst_n, o_out_valid && o_bad_address, o_read_data == 8'd0)

    // a taken beat always passes the decode state before the next one is taken
    `PBROT_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a new result beat only follows a taken read beat
    `PBROT_ASSERT_NOW(a_read_latency, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && !o_in_stall && (i_req_type == REQ_READ), 3))

    // held result beat keeps its payload
    `PBROT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_data) && $stable(o_bad_address))

    // nothing leaves right after reset
    `PBROT_ASSERT_NEXT(a_reset_clears, i_clk, 1'b1, !i_rst_n, !o_out_valid)

endmodule

bind packed_bitmap_rotate_90_core pbrot_chk u_pbrot_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_req_type    (i_req_type),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_read_data   (o_read_data),
    .o_bad_address (o_bad_address)
);
